FILE: sv/i2c_eeprom_master_sequencer_top_macros.svh
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer assertion macros
// Shared concurrent assertion forms, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_MASTER_SEQUENCER_TOP_MACROS_SVH
`define I2C_EEPROM_MASTER_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define I2CEM_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("i2cem assertion failed");
// next-cycle implication
`define I2CEM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("i2cem assertion failed");
`else
`define I2CEM_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define I2CEM_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

FILE: sv/i2cem_pkg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer package
// Word types, status codes and shared constants.
// ----------------------------------------------------------------------------
package i2cem_pkg;

    // defaults
    localparam int BUF_DEPTH_DEF  = 128;
    localparam int CFG_IDX_W      = 1;

    // request types
    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_EVENT  = 2'd1;
    localparam logic [1:0] REQ_BUF_WR = 2'd2;
    localparam logic [1:0] REQ_BUF_RD = 2'd3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = 1'd1;

    localparam logic [6:0] DEV_ADDR_RST    = 7'd80;
    localparam logic [2:0] RETRY_LIMIT_RST = 3'd5;

    // bus status codes
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RSTART      = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
    localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
    localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_WR_ADDR   = 3'd1;
    localparam logic [2:0] ERR_WR_DATA   = 3'd2;
    localparam logic [2:0] ERR_RD_ADDR   = 3'd3;
    localparam logic [2:0] ERR_RD_DATA   = 3'd4;

    // ack control codes
    localparam logic [1:0] ACK_KEEP = 2'd0;
    localparam logic [1:0] ACK_ACK  = 2'd1;
    localparam logic [1:0] ACK_NACK = 2'd2;

    // source of the transmit byte, resolved one stage later
    typedef enum logic [1:0] {
        TX_NONE,
        TX_CONST,
        TX_MEM,
        TX_LAST
    } tx_src_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        is_read;
        logic [15:0] mem_address;
        logic [7:0]  byte_count;
        logic [7:0]  status_code;
        logic [7:0]  rx_byte;
        logic [6:0]  buf_index;
        logic [7:0]  buf_data;
    } cmd_word_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        send_start;
        logic        send_stop;
        logic [1:0]  ack_control;
        logic        busy_flag;
        logic [2:0]  error_code;
        logic [7:0]  read_data;
    } rsp_word_t;

    // result record handed from the control stage to the output stage
    typedef struct packed {
        tx_src_t     tx_src;
        logic [7:0]  tx_byte;
        logic        send_start;
        logic        send_stop;
        logic [1:0]  ack_control;
        logic        busy_flag;
        logic [2:0]  error_code;
        logic        rd_sel;
    } stage_rec_t;

    // buffer access strobes
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

FILE: sv/i2cem_if.sv
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer channels
// Valid/ready channels for commands, responses and config writes.
// ----------------------------------------------------------------------------
interface i2cem_cmd_if;
    import i2cem_pkg::*;
    logic      valid;
    logic      ready;
    cmd_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cem_rsp_if;
    import i2cem_pkg::*;
    logic      valid;
    logic      ready;
    rsp_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cem_cfg_if;
    import i2cem_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/i2cem_buf.sv
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer data buffer
// Single-port byte memory with registered read data.
// ----------------------------------------------------------------------------
module i2cem_buf #(
    parameter int BUF_DEPTH = i2cem_pkg::BUF_DEPTH_DEF,
    parameter int PTR_W     = $clog2(BUF_DEPTH)
) (
    input  logic                clk,
    input  i2cem_pkg::mem_ctl_t mem_ctl,
    input  logic [PTR_W-1:0]    addr,
    input  logic [7:0]          wdata,
    output logic [7:0]          rdata
);
    import i2cem_pkg::*;

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (mem_ctl.we)
        begin
            mem[addr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (mem_ctl.re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/i2cem_ctrl.sv
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer control stage
// Holds transfer state and config, decodes each word, drives the buffer.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_master_sequencer_top_macros.svh"

module i2cem_ctrl #(
    parameter int BUF_DEPTH = i2cem_pkg::BUF_DEPTH_DEF,
    parameter int PTR_W     = $clog2(BUF_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    i2cem_cmd_if.sink             cmd,
    i2cem_cfg_if.sink             cfg,
    input  logic                  in_ready,
    output i2cem_pkg::stage_rec_t rec,
    output i2cem_pkg::mem_ctl_t   mem_ctl,
    output logic [PTR_W-1:0]      mem_addr,
    output logic [7:0]            mem_wdata
);
    import i2cem_pkg::*;

    typedef logic [PTR_W-1:0] idx_tab_t [128];

    // buffer index folded into the buffer depth, built without division
    function automatic idx_tab_t mod_table();
        idx_tab_t   t;
        int         r;
        r = 0;
        for (int i = 0; i < 128; i++)
        begin
            t[i] = PTR_W'(r);
            r = (r + 1 == BUF_DEPTH) ? 0 : r + 1;
        end
        return t;
    endfunction

    localparam idx_tab_t IDX_TAB = mod_table();
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUF_DEPTH - 1);

    logic             accept;
    logic [6:0]       dev_addr_reg;
    logic [2:0]       retry_limit_reg;

    logic             busy_reg,     busy_next;
    logic             read_mode_reg, read_mode_next;
    logic             low_sent_reg, low_sent_next;
    logic [7:0]       bytes_reg,    bytes_next;
    logic [PTR_W-1:0] ptr_reg,      ptr_next;
    logic [2:0]       retries_reg,  retries_next;
    logic [2:0]       err_reg,      err_next;
    logic [15:0]      maddr_reg,    maddr_next;

    logic [PTR_W-1:0] ptr_inc;
    logic [7:0]       dev_wr_byte;
    logic [7:0]       dev_rd_byte;
    logic             stop;

    assign accept      = cmd.valid & in_ready;
    assign cmd.ready   = in_ready;
    assign cfg.ready   = 1'b1;
    assign ptr_inc     = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
    assign dev_wr_byte = {dev_addr_reg, 1'b0};
    assign dev_rd_byte = {dev_addr_reg, 1'b1};
    assign mem_wdata   = (cmd.data.req_type == REQ_BUF_WR) ? cmd.data.buf_data
                                                           : cmd.data.rx_byte;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg    <= DEV_ADDR_RST;
            retry_limit_reg <= RETRY_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DEVICE_ADDRESS: dev_addr_reg    <= cfg.data[6:0];
                CFG_RETRY_LIMIT:    retry_limit_reg <= cfg.data[2:0];
            endcase
        end
    end

    // next state, buffer access and result record
    always_comb
    begin
        busy_next      = busy_reg;
        read_mode_next = read_mode_reg;
        low_sent_next  = low_sent_reg;
        bytes_next     = bytes_reg;
        ptr_next       = ptr_reg;
        retries_next   = retries_reg;
        err_next       = err_reg;
        maddr_next     = maddr_reg;
        stop           = 1'b0;
        mem_ctl        = '0;
        mem_addr       = ptr_reg;
        rec            = '0;
        rec.tx_src     = TX_NONE;

        if (accept)
        begin
            unique case (cmd.data.req_type)
                REQ_START:
                begin
                    if (!busy_reg)
                    begin
                        busy_next      = 1'b1;
                        read_mode_next = cmd.data.is_read;
                        maddr_next     = cmd.data.mem_address;
                        bytes_next     = cmd.data.byte_count;
                        ptr_next       = '0;
                        low_sent_next  = 1'b0;
                        retries_next   = retry_limit_reg;
                        err_next       = ERR_NONE;
                        rec.send_start = 1'b1;
                    end
                end
                REQ_EVENT:
                begin
                    if (busy_reg && !read_mode_reg)
                    begin
                        // write transfer
                        case (cmd.data.status_code) inside
                            ST_START, ST_RSTART:
                            begin
                                rec.tx_src  = TX_CONST;
                                rec.tx_byte = dev_wr_byte;
                            end
                            ST_SLA_W_ACK:
                            begin
                                rec.tx_src  = TX_CONST;
                                rec.tx_byte = maddr_reg[15:8];
                            end
                            ST_SLA_W_NACK:
                            begin
                                if (retries_reg != 3'd0)
                                begin
                                    rec.tx_src   = TX_CONST;
                                    rec.tx_byte  = dev_wr_byte;
                                    retries_next = retries_reg - 3'd1;
                                end
                                else
                                begin
                                    stop     = 1'b1;
                                    err_next = ERR_WR_ADDR;
                                end
                            end
                            ST_DATA_W_ACK:
                            begin
                                if (!low_sent_reg)
                                begin
                                    rec.tx_src    = TX_CONST;
                                    rec.tx_byte   = maddr_reg[7:0];
                                    low_sent_next = 1'b1;
                                end
                                else if (bytes_reg != 8'd0)
                                begin
                                    bytes_next  = bytes_reg - 8'd1;
                                    rec.tx_src  = TX_MEM;
                                    mem_ctl.re  = 1'b1;
                                    ptr_next    = ptr_inc;
                                end
                                else
                                begin
                                    stop = 1'b1;
                                end
                            end
                            ST_DATA_W_NACK:
                            begin
                                if (bytes_reg == 8'd0 || retries_reg == 3'd0)
                                begin
                                    stop     = 1'b1;
                                    err_next = ERR_WR_DATA;
                                end
                                else
                                begin
                                    rec.tx_src   = TX_LAST;
                                    retries_next = retries_reg - 3'd1;
                                end
                            end
                            default:
                            begin
                                stop = 1'b1;
                            end
                        endcase
                    end
                    else if (busy_reg)
                    begin
                        // read transfer
                        case (cmd.data.status_code) inside
                            ST_START, ST_RSTART:
                            begin
                                rec.tx_src  = TX_CONST;
                                rec.tx_byte = dev_rd_byte;
                            end
                            ST_SLA_R_ACK:
                            begin
                                rec.ack_control = ACK_ACK;
                            end
                            ST_SLA_R_NACK:
                            begin
                                if (retries_reg != 3'd0)
                                begin
                                    rec.send_start = 1'b1;
                                    retries_next   = retries_reg - 3'd1;
                                end
                                else
                                begin
                                    stop     = 1'b1;
                                    err_next = ERR_RD_ADDR;
                                end
                            end
                            ST_DATA_R_ACK:
                            begin
                                if (bytes_reg > 8'd1)
                                begin
                                    bytes_next = bytes_reg - 8'd1;
                                    mem_ctl.we = 1'b1;
                                    ptr_next   = ptr_inc;
                                end
                                else
                                begin
                                    // last byte is stored, zero count stores nothing
                                    mem_ctl.we      = (bytes_reg == 8'd1);
                                    bytes_next      = 8'd0;
                                    rec.ack_control = ACK_NACK;
                                end
                            end
                            ST_DATA_R_NACK:
                            begin
                                if (bytes_reg == 8'd0)
                                begin
                                    stop = 1'b1;
                                end
                                else if (retries_reg != 3'd0)
                                begin
                                    mem_ctl.we   = 1'b1;
                                    ptr_next     = ptr_inc;
                                    retries_next = retries_reg - 3'd1;
                                end
                                else
                                begin
                                    stop     = 1'b1;
                                    err_next = ERR_RD_DATA;
                                end
                            end
                            default:
                            begin
                                stop = 1'b1;
                            end
                        endcase
                    end
                end
                REQ_BUF_WR:
                begin
                    mem_ctl.we = 1'b1;
                    mem_addr   = IDX_TAB[cmd.data.buf_index];
                end
                REQ_BUF_RD:
                begin
                    mem_ctl.re = 1'b1;
                    mem_addr   = IDX_TAB[cmd.data.buf_index];
                    rec.rd_sel = 1'b1;
                end
            endcase

            // every stop ends the transfer
            if (stop)
            begin
                rec.send_stop = 1'b1;
                low_sent_next = 1'b0;
                busy_next     = 1'b0;
            end
        end

        rec.busy_flag  = busy_next;
        rec.error_code = err_next;
    end

    // transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            read_mode_reg <= 1'b0;
            low_sent_reg  <= 1'b0;
            bytes_reg     <= '0;
            ptr_reg       <= '0;
            retries_reg   <= '0;
            err_reg       <= ERR_NONE;
            maddr_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            read_mode_reg <= read_mode_next;
            low_sent_reg  <= low_sent_next;
            bytes_reg     <= bytes_next;
            ptr_reg       <= ptr_next;
            retries_reg   <= retries_next;
            err_reg       <= err_next;
            maddr_reg     <= maddr_next;
        end
    end

    `I2CEM_ASSERT_NOW(a_mem_one_op, clk, rst_n, mem_ctl.we, !mem_ctl.re)
    `I2CEM_ASSERT_NOW(a_err_idle, clk, rst_n, err_reg != ERR_NONE, !busy_reg)
    `I2CEM_ASSERT_NOW(a_low_sent_busy, clk, rst_n, low_sent_reg, busy_reg)

endmodule

FILE: sv/i2cem_out.sv
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer output stage
// Pairs each record with buffer read data and holds the response word.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_master_sequencer_top_macros.svh"

module i2cem_out (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  i2cem_pkg::stage_rec_t rec,
    input  logic [7:0]            rdata,
    output logic                  in_ready,
    i2cem_rsp_if.source           rsp
);
    import i2cem_pkg::*;

    logic       p1_valid_reg,  p1_valid_next;
    stage_rec_t p1_rec_reg;
    logic       out_valid_reg, out_valid_next;
    rsp_word_t  out_word_reg,  out_word_next;
    logic [7:0] last_sent_reg, last_sent_next;
    logic       advance;
    logic [7:0] tx_resolved;

    assign advance  = p1_valid_reg & (~out_valid_reg | rsp.ready);
    assign in_ready = ~p1_valid_reg | ~out_valid_reg | rsp.ready;

    // resolve the transmit byte in word order
    always_comb
    begin
        case (p1_rec_reg.tx_src)
            TX_CONST: tx_resolved = p1_rec_reg.tx_byte;
            TX_MEM:   tx_resolved = rdata;
            TX_LAST:  tx_resolved = last_sent_reg;
            default:  tx_resolved = 8'd0;
        endcase
    end

    // response word and stage occupancy
    always_comb
    begin
        p1_valid_next  = accept | (p1_valid_reg & ~advance);
        out_valid_next = advance | (out_valid_reg & ~rsp.ready);
        out_word_next  = out_word_reg;
        last_sent_next = last_sent_reg;
        if (advance)
        begin
            out_word_next.tx_valid    = (p1_rec_reg.tx_src != TX_NONE);
            out_word_next.tx_byte     = tx_resolved;
            out_word_next.send_start  = p1_rec_reg.send_start;
            out_word_next.send_stop   = p1_rec_reg.send_stop;
            out_word_next.ack_control = p1_rec_reg.ack_control;
            out_word_next.busy_flag   = p1_rec_reg.busy_flag;
            out_word_next.error_code  = p1_rec_reg.error_code;
            out_word_next.read_data   = p1_rec_reg.rd_sel ? rdata : 8'd0;
            if (p1_rec_reg.tx_src != TX_NONE)
            begin
                last_sent_next = tx_resolved;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_sent_reg <= 8'd0;
        end
        else
        begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
            last_sent_reg <= last_sent_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_rec_reg <= rec;
        end
        out_word_reg <= out_word_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_word_reg;

    `I2CEM_ASSERT_NEXT(a_p1_held, clk, rst_n, p1_valid_reg && !advance, p1_valid_reg)
    `I2CEM_ASSERT_NEXT(a_adv_out, clk, rst_n, advance, out_valid_reg)
    `I2CEM_ASSERT_NOW(a_full_stall, clk, rst_n,
        p1_valid_reg && out_valid_reg && !rsp.ready, !in_ready)

endmodule

FILE: sv/i2c_eeprom_master_sequencer_top.sv
// ----------------------------------------------------------------------------
// I2C EEPROM master sequencer
// Status-driven bus action sequencer for a 16-bit addressed serial EEPROM.
// ----------------------------------------------------------------------------
// Each command word (start, bus status event, buffer write, buffer read) yields
// exactly one response word; a new command word is taken every cycle while the
// response side keeps up. The single-port data buffer registers its read data,
// so the transmit byte of a data phase and the byte of a buffer read are taken
// from the buffer read register alongside the held command record, then pass
// through the response register. Config writes are taken at any time but must
// only be issued while the block is idle. The buffer holds no reset value:
// entries read before they are written return undefined data. No clearing
// pass runs after reset.
module i2c_eeprom_master_sequencer_top #(
    parameter int BUF_DEPTH = i2cem_pkg::BUF_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    i2cem_cmd_if.sink   cmd,
    i2cem_rsp_if.source rsp,
    i2cem_cfg_if.sink   cfg
);
    import i2cem_pkg::*;

    localparam int PTR_W = $clog2(BUF_DEPTH);

    stage_rec_t       rec;
    mem_ctl_t         mem_ctl;
    logic [PTR_W-1:0] mem_addr;
    logic [7:0]       mem_wdata;
    logic [7:0]       mem_rdata;
    logic             in_ready;
    logic             accept;

    assign accept = cmd.valid & in_ready;

    i2cem_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .PTR_W     (PTR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .in_ready  (in_ready),
        .rec       (rec),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata)
    );

    i2cem_buf #(
        .BUF_DEPTH (BUF_DEPTH),
        .PTR_W     (PTR_W)
    ) u_buf (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .addr    (mem_addr),
        .wdata   (mem_wdata),
        .rdata   (mem_rdata)
    );

    i2cem_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rec      (rec),
        .rdata    (mem_rdata),
        .in_ready (in_ready),
        .rsp      (rsp)
    );

endmodule

FILE: dv/tb_i2c_eeprom_master_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C EEPROM master sequencer testbench
// Sends start, bus status, buffer write and buffer read words to the
// sequencer. A cycle-free model predicts each response word, and a checker
// compares every response field by field, in order. Directed cases come
// first. Randomized write and read transfers follow, in phases with different
// idle and stall rates and with different register settings.
// ----------------------------------------------------------------------------
module tb_i2c_eeprom_master_sequencer_top;
    import i2cem_pkg::*;

    localparam int         RANDOM_WORDS = 1650;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         MAX_REPORTS  = 40;
    localparam int         TIMEOUT_NS   = 12 * 400_000;
    // status code that no transfer expects; ends any transfer with a stop
    localparam logic [7:0] ST_UNKNOWN   = 8'h00;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    i2cem_cmd_if cmd_ch ();
    i2cem_rsp_if rsp_ch ();
    i2cem_cfg_if cfg_ch ();

    i2c_eeprom_master_sequencer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // sequencer model: registers
    logic [6:0]  dev_addr;
    logic [2:0]  retry_lim;
    // sequencer model: transfer state
    logic        xfer_busy;
    logic        xfer_read;
    logic        low_sent;
    logic [7:0]  bytes_left;
    logic [6:0]  buf_ptr;
    logic [2:0]  retries;
    logic [2:0]  err;
    logic [15:0] mem_addr;
    logic [7:0]  last_byte;
    logic [7:0]  buf_mem [BUF_DEPTH_DEF];
    bit          written [BUF_DEPTH_DEF];

    rsp_word_t   pending_actions [$];

    int idle_pct;
    int stall_pct;
    int words_sent;
    int active_words;
    int responses_checked;
    int mismatches;
    int transfers;
    int failed_transfers;

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------------
    function automatic void reset_model();
        dev_addr   = DEV_ADDR_RST;
        retry_lim  = RETRY_LIMIT_RST;
        xfer_busy  = 1'b0;
        xfer_read  = 1'b0;
        low_sent   = 1'b0;
        bytes_left = '0;
        buf_ptr    = '0;
        retries    = '0;
        err        = ERR_NONE;
        mem_addr   = '0;
        last_byte  = '0;
        for (int i = 0; i < BUF_DEPTH_DEF; i++)
        begin
            buf_mem[i] = '0;
            written[i] = 1'b0;
        end
    endfunction

    function automatic void put_byte(inout rsp_word_t r, input logic [7:0] b);
        r.tx_valid = 1'b1;
        r.tx_byte  = b;
        last_byte  = b;
    endfunction

    // every stop ends the transfer; a nonzero code also latches the error
    function automatic void end_transfer(inout rsp_word_t r, input logic [2:0] code);
        r.send_stop = 1'b1;
        low_sent    = 1'b0;
        xfer_busy   = 1'b0;
        if (code != ERR_NONE)
        begin
            err = code;
            failed_transfers++;
        end
    endfunction

    function automatic void store_rx(logic [7:0] b);
        buf_mem[buf_ptr] = b;
        written[buf_ptr] = 1'b1;
    endfunction

    function automatic rsp_word_t predict_action(cmd_word_t c);
        rsp_word_t r;
        r = '0;
        if (!((c.req_type == REQ_START && xfer_busy) || (c.req_type == REQ_EVENT && !xfer_busy)))
            active_words++;
        case (c.req_type)
            REQ_START:
            begin
                if (!xfer_busy)
                begin
                    xfer_busy    = 1'b1;
                    xfer_read    = c.is_read;
                    mem_addr     = c.mem_address;
                    bytes_left   = c.byte_count;
                    buf_ptr      = '0;
                    low_sent     = 1'b0;
                    retries      = retry_lim;
                    err          = ERR_NONE;
                    r.send_start = 1'b1;
                end
            end
            REQ_EVENT:
            begin
                if (xfer_busy && xfer_read)
                begin
                    case (c.status_code)
                        ST_START, ST_RSTART: put_byte(r, {dev_addr, 1'b1});
                        ST_SLA_R_ACK:        r.ack_control = ACK_ACK;
                        ST_SLA_R_NACK:
                        begin
                            if (retries != 0)
                            begin
                                r.send_start = 1'b1;
                                retries--;
                            end
                            else
                                end_transfer(r, ERR_RD_ADDR);
                        end
                        ST_DATA_R_ACK:
                        begin
                            if (bytes_left > 1)
                            begin
                                bytes_left--;
                                store_rx(c.rx_byte);
                                buf_ptr++;
                            end
                            else
                            begin
                                // last byte (or zero count): pointer holds, NACK next
                                if (bytes_left == 1)
                                    store_rx(c.rx_byte);
                                bytes_left    = '0;
                                r.ack_control = ACK_NACK;
                            end
                        end
                        ST_DATA_R_NACK:
                        begin
                            if (bytes_left == 0)
                                end_transfer(r, ERR_NONE);
                            else if (retries != 0)
                            begin
                                store_rx(c.rx_byte);
                                buf_ptr++;
                                retries--;
                            end
                            else
                                end_transfer(r, ERR_RD_DATA);
                        end
                        default: end_transfer(r, ERR_NONE);
                    endcase
                end
                else if (xfer_busy)
                begin
                    case (c.status_code)
                        ST_START, ST_RSTART: put_byte(r, {dev_addr, 1'b0});
                        ST_SLA_W_ACK:        put_byte(r, mem_addr[15:8]);
                        ST_SLA_W_NACK:
                        begin
                            if (retries != 0)
                            begin
                                put_byte(r, {dev_addr, 1'b0});
                                retries--;
                            end
                            else
                                end_transfer(r, ERR_WR_ADDR);
                        end
                        ST_DATA_W_ACK:
                        begin
                            if (!low_sent)
                            begin
                                put_byte(r, mem_addr[7:0]);
                                low_sent = 1'b1;
                            end
                            else if (bytes_left != 0)
                            begin
                                bytes_left--;
                                put_byte(r, buf_mem[buf_ptr]);
                                buf_ptr++;
                            end
                            else
                                end_transfer(r, ERR_NONE);
                        end
                        ST_DATA_W_NACK:
                        begin
                            if (bytes_left == 0 || retries == 0)
                                end_transfer(r, ERR_WR_DATA);
                            else
                            begin
                                put_byte(r, last_byte);
                                retries--;
                            end
                        end
                        default: end_transfer(r, ERR_NONE);
                    endcase
                end
            end
            REQ_BUF_WR:
            begin
                buf_mem[c.buf_index] = c.buf_data;
                written[c.buf_index] = 1'b1;
            end
            default: r.read_data = buf_mem[c.buf_index];
        endcase
        r.busy_flag  = xfer_busy;
        r.error_code = err;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // response side: random stall and in-order check
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
    endtask

    always @(posedge clk)
    begin : check_actions
        rsp_word_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
        begin
            if (pending_actions.size() == 0)
                report_mismatch("response word with no command pending");
            else
            begin
                want = pending_actions.pop_front();
                responses_checked++;
                check_field("tx_valid",    want.tx_valid,    rsp_ch.data.tx_valid);
                check_field("tx_byte",     want.tx_byte,     rsp_ch.data.tx_byte);
                check_field("send_start",  want.send_start,  rsp_ch.data.send_start);
                check_field("send_stop",   want.send_stop,   rsp_ch.data.send_stop);
                check_field("ack_control", want.ack_control, rsp_ch.data.ack_control);
                check_field("busy_flag",   want.busy_flag,   rsp_ch.data.busy_flag);
                check_field("error_code",  want.error_code,  rsp_ch.data.error_code);
                check_field("read_data",   want.read_data,   rsp_ch.data.read_data);
            end
        end
    end

    // ------------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------------
    // all fields random; only the request type is fixed
    function automatic cmd_word_t random_cmd(logic [1:0] req);
        cmd_word_t   c;
        logic [31:0] a;
        logic [31:0] b;
        a             = $urandom;
        b             = $urandom;
        c.req_type    = req;
        c.is_read     = a[0];
        c.mem_address = a[16:1];
        c.byte_count  = a[24:17];
        c.status_code = b[7:0];
        c.rx_byte     = b[15:8];
        c.buf_index   = b[22:16];
        c.buf_data    = {a[31:25], b[23]};
        return c;
    endfunction

    task automatic send_word(cmd_word_t c);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        pending_actions.push_back(predict_action(c));
        words_sent++;
    endtask

    // a data phase never sends a buffer entry that was never written
    task automatic send_status(logic [7:0] st);
        cmd_word_t c;
        if (xfer_busy && !xfer_read && st == ST_DATA_W_ACK && low_sent && bytes_left != 0
            && !written[buf_ptr])
        begin
            c           = random_cmd(REQ_BUF_WR);
            c.buf_index = buf_ptr;
            send_word(c);
        end
        c             = random_cmd(REQ_EVENT);
        c.status_code = st;
        send_word(c);
    endtask

    task automatic start_transfer(bit rd, logic [15:0] addr, logic [7:0] cnt);
        cmd_word_t c;
        c             = random_cmd(REQ_START);
        c.is_read     = rd;
        c.mem_address = addr;
        c.byte_count  = cnt;
        send_word(c);
    endtask

    // buffer read of a written entry; writes one if none exists
    task automatic read_buffer_entry();
        cmd_word_t c;
        c = random_cmd(REQ_BUF_RD);
        for (int k = 0; k < BUF_DEPTH_DEF && !written[c.buf_index]; k++)
            c.buf_index++;
        if (!written[c.buf_index])
            c.req_type = REQ_BUF_WR;
        send_word(c);
    endtask

    // buffer traffic, or a word the block ignores in its current state
    task automatic send_side_word();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            send_word(random_cmd(REQ_BUF_WR));
        else if (r < 80)
            read_buffer_entry();
        else if (xfer_busy)
            send_word(random_cmd(REQ_START));
        else
            send_word(random_cmd(REQ_EVENT));
    endtask

    task automatic finish_transfer();
        if (xfer_busy)
            send_status(ST_UNKNOWN);
    endtask

    task automatic drain_responses();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_actions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // registers change only with no transfer open and nothing in flight
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        finish_transfer();
        drain_responses();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        if (idx == CFG_DEVICE_ADDRESS)
            dev_addr = value[6:0];
        else
            retry_lim = value[2:0];
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // next bus status, mostly what a well-behaved slave would produce
    function automatic logic [7:0] pick_status(int step, int noise_pct);
        int r;
        int nack_pct;
        r        = $urandom_range(99);
        nack_pct = (bytes_left > 16) ? 1 : 12;
        if ($urandom_range(99) < noise_pct)
            return 8'($urandom);
        if (step == 0)
            return (r < 70) ? ST_START : ST_RSTART;
        if (!xfer_read)
        begin
            if (step == 1)
                return (r < 85) ? ST_SLA_W_ACK : ST_SLA_W_NACK;
            return (r >= nack_pct) ? ST_DATA_W_ACK : ST_DATA_W_NACK;
        end
        if (step == 1)
            return (r < 85) ? ST_SLA_R_ACK : ST_SLA_R_NACK;
        if (bytes_left == 0)
            return (r < 80) ? ST_DATA_R_NACK : ST_DATA_R_ACK;
        return (r >= nack_pct) ? ST_DATA_R_ACK : ST_DATA_R_NACK;
    endfunction

    task automatic run_transfer(bit rd, int noise_pct);
        int          r;
        int          step;
        int          n;
        logic [7:0]  cnt;
        logic [7:0]  st;
        logic [31:0] a;
        finish_transfer();
        r = $urandom_range(99);
        a = $urandom;
        if (r < 4)
            cnt = 8'd128;
        else if (r < 12)
            cnt = 8'($urandom_range(128));
        else
            cnt = 8'($urandom_range(6));
        start_transfer(rd, a[15:0], cnt);
        transfers++;
        step = 0;
        n    = 0;
        while (xfer_busy && n < 700)
        begin
            if ($urandom_range(99) < 6)
                send_side_word();
            st = pick_status(step, noise_pct);
            send_status(st);
            case (st)
                ST_START, ST_RSTART:        step = 1;
                ST_SLA_W_ACK, ST_SLA_R_ACK: step = 2;
                ST_SLA_R_NACK:              step = 0;
                default: ;
            endcase
            n++;
        end
        finish_transfer();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // buffer entries and data at their extremes
    task automatic test_buffer_access();
        cmd_word_t c;
        c           = random_cmd(REQ_BUF_WR);
        c.buf_index = 7'd0;
        c.buf_data  = 8'h00;
        send_word(c);
        c.buf_index = 7'd127;
        c.buf_data  = 8'hFF;
        send_word(c);
        c.req_type  = REQ_BUF_RD;
        send_word(c);
        c.buf_index = 7'd0;
        send_word(c);
    endtask

    // one-byte write to the top address, then a data NACK with nothing left
    task automatic test_write_transfer();
        start_transfer(1'b0, 16'hFFFF, 8'd1);
        send_status(ST_START);
        send_status(ST_SLA_W_ACK);
        send_status(ST_DATA_W_ACK);
        send_status(ST_DATA_W_ACK);
        send_status(ST_DATA_W_NACK);
    endtask

    // zero-count read opened by a repeated start, then a status while idle
    task automatic test_read_transfer();
        start_transfer(1'b1, 16'h0000, 8'd0);
        send_status(ST_RSTART);
        send_status(ST_SLA_R_ACK);
        send_status(ST_DATA_R_ACK);
        send_status(ST_DATA_R_NACK);
        send_status(ST_DATA_R_ACK);
    endtask

    // address NACKs with no retry budget, start while busy, unknown status
    task automatic test_nack_retries();
        write_register(CFG_RETRY_LIMIT, 8'd0);
        write_register(CFG_DEVICE_ADDRESS, 8'd127);
        start_transfer(1'b0, 16'h1234, 8'd2);
        send_status(ST_START);
        send_status(ST_SLA_W_NACK);
        start_transfer(1'b1, 16'h00FF, 8'd2);
        send_status(ST_START);
        send_status(ST_SLA_R_NACK);
        start_transfer(1'b0, 16'h8000, 8'd3);
        start_transfer(1'b1, 16'h0001, 8'd128);
        send_status(8'hFF);
        write_register(CFG_DEVICE_ADDRESS, 8'd0);
        write_register(CFG_RETRY_LIMIT, 8'd7);
    endtask

    task automatic test_random_traffic();
        int goal;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 45; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 8;  stall_pct = 8;  end
            endcase
            case (ph)
                1:
                begin
                    write_register(CFG_DEVICE_ADDRESS, 8'd127);
                    write_register(CFG_RETRY_LIMIT, 8'd7);
                end
                2:
                begin
                    write_register(CFG_DEVICE_ADDRESS, 8'd0);
                    write_register(CFG_RETRY_LIMIT, 8'd0);
                end
                default:
                begin
                    write_register(CFG_DEVICE_ADDRESS, 8'($urandom_range(127)));
                    write_register(CFG_RETRY_LIMIT, 8'($urandom_range(7)));
                end
            endcase
            goal = active_words + RANDOM_WORDS / 4;
            while (active_words < goal)
            begin
                if ($urandom_range(99) < 15)
                    send_side_word();
                else
                    run_transfer(1'($urandom_range(1)), ($urandom_range(99) < 20) ? 10 : 0);
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        idle_pct     = 0;
        stall_pct    = 0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        reset_model();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_buffer_access();
        test_write_transfer();
        test_read_transfer();
        test_nack_retries();
        test_random_traffic();
        finish_transfer();
        drain_responses();

        $display("sent %0d words (%0d acted on), %0d random transfers, %0d bus errors",
                 words_sent, active_words, transfers, failed_transfers);
        $display("checked %0d response words, %0d mismatches", responses_checked, mismatches);
        if (mismatches == 0 && pending_actions.size() == 0)
            $display("tb_i2c_eeprom_master_sequencer_top: PASS");
        else
            $display("tb_i2c_eeprom_master_sequencer_top: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d responses outstanding", pending_actions.size());
        $display("tb_i2c_eeprom_master_sequencer_top: FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/i2cem_pkg.sv
sv/i2cem_if.sv
sv/i2cem_buf.sv
sv/i2cem_ctrl.sv
sv/i2cem_out.sv
sv/i2c_eeprom_master_sequencer_top.sv
dv/tb_i2c_eeprom_master_sequencer_top.sv
